[rtl/necir_pkg.sv]
// ----------------------------------------------------------------------------
// necir_pkg
// Shared constants and types for the NEC infrared edge interval decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

  // Timestamp width default and the fixed width of the edge time port
  localparam int unsigned TIMESTAMP_BITS_DEF = 32;
  localparam int unsigned EDGE_TIME_BITS     = 32;

  // Field widths
  localparam int unsigned PIN_BITS    = 4;
  localparam int unsigned TOL_BITS    = 10;
  localparam int unsigned HALF_BITS   = 16;
  localparam int unsigned FRAME_BITS  = 32;
  localparam int unsigned COUNT_BITS  = 6;
  localparam int unsigned INDEX_BITS  = 5;

  // Configuration port
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LISTEN_PIN   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE_US = 1'b1;

  // Register reset values
  localparam logic [PIN_BITS-1:0] LISTEN_PIN_RST   = 4'd0;
  localparam logic [TOL_BITS-1:0] TOLERANCE_US_RST = 10'd200;

  // Interval limits in microseconds
  localparam int unsigned HDR_LOW_US     = 13000;
  localparam int unsigned HDR_HIGH_US    = 14000;
  localparam int unsigned RPT_LOW_US     = 11000;
  localparam int unsigned RPT_HIGH_US    = 12000;
  localparam int unsigned ZERO_TARGET_US = 1120;
  localparam int unsigned ONE_TARGET_US  = 2250;

  // Width that holds a bit target plus the largest tolerance
  localparam int unsigned WIN_BITS = 12;

  // Classification of one edge interval
  typedef struct packed {
    logic header;
    logic repeat_code;
    logic bit_zero;
    logic bit_one;
  } interval_class_t;

endpackage : necir_pkg

`default_nettype wire

[rtl/necir_interval_cls.sv]
// ----------------------------------------------------------------------------
// necir_interval_cls
// Classifies one edge interval as header, repeat, data zero or data one.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_interval_cls
  import necir_pkg::*;
#(
  parameter int unsigned TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  wire logic [TIMESTAMP_BITS-1:0] delta,
  input  wire logic [TOL_BITS-1:0]       tolerance_us,
  output interval_class_t                cls
);

  localparam logic [TIMESTAMP_BITS-1:0] HDR_LO = TIMESTAMP_BITS'(HDR_LOW_US);
  localparam logic [TIMESTAMP_BITS-1:0] HDR_HI = TIMESTAMP_BITS'(HDR_HIGH_US);
  localparam logic [TIMESTAMP_BITS-1:0] RPT_LO = TIMESTAMP_BITS'(RPT_LOW_US);
  localparam logic [TIMESTAMP_BITS-1:0] RPT_HI = TIMESTAMP_BITS'(RPT_HIGH_US);
  localparam logic [WIN_BITS-1:0]       ZERO_T = WIN_BITS'(ZERO_TARGET_US);
  localparam logic [WIN_BITS-1:0]       ONE_T  = WIN_BITS'(ONE_TARGET_US);

  logic [WIN_BITS-1:0] tol_ext;
  logic [WIN_BITS-1:0] zero_lo;
  logic [WIN_BITS-1:0] zero_hi;
  logic [WIN_BITS-1:0] one_lo;
  logic [WIN_BITS-1:0] one_hi;

  // Build the data bit windows, clamping the low edge at zero
  always_comb begin
    tol_ext = WIN_BITS'(tolerance_us);
    zero_lo = (ZERO_T > tol_ext) ? (ZERO_T - tol_ext) : '0;
    zero_hi = ZERO_T + tol_ext;
    one_lo  = (ONE_T > tol_ext) ? (ONE_T - tol_ext) : '0;
    one_hi  = ONE_T + tol_ext;
  end

  // Compare the interval against the header, repeat and bit windows
  always_comb begin
    cls.header      = (delta > HDR_LO) && (delta < HDR_HI);
    cls.repeat_code = (delta > RPT_LO) && (delta < RPT_HI);
    cls.bit_zero    = (delta >= TIMESTAMP_BITS'(zero_lo)) &&
                      (delta <= TIMESTAMP_BITS'(zero_hi));
    cls.bit_one     = (delta >= TIMESTAMP_BITS'(one_lo)) &&
                      (delta <= TIMESTAMP_BITS'(one_hi));
  end

endmodule : necir_interval_cls

`default_nettype wire

[rtl/nec_ir_edge_interval_decoder_core.sv]
// An accepted edge beat passes the edge register, then the result register, before its result beat shows on out_*.
// Throughput: one edge per cycle; in_stall rises only while a result waits
//   on a stalled output and the edge register is full.
// Reset (synchronous, rst_n low): idle, bit count and word cleared, previous
//   edge time 0, held frame 0, listen_pin 0, tolerance_us 200.
// ----------------------------------------------------------------------------
// nec_ir_edge_interval_decoder_core
// NEC infrared decoder driven by falling-edge timestamps on one selected pin.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_edge_interval_decoder_core
  import necir_pkg::*;
#(
  parameter int unsigned TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Edge channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PIN_BITS-1:0]       in_pin_number,
  input  wire logic [EDGE_TIME_BITS-1:0] in_edge_time_us,
  // Result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [HALF_BITS-1:0]           out_frame_address,
  output logic [HALF_BITS-1:0]           out_frame_command,
  output logic                           out_repeat_flag,
  // Configuration write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  logic [PIN_BITS-1:0] listen_pin_r;
  logic [TOL_BITS-1:0] tolerance_us_r;

  // Edge register
  logic                      edge_valid_r;
  logic [TIMESTAMP_BITS-1:0] edge_time_r;

  // Decoder state
  logic                      in_frame_r;
  logic                      in_frame_nxt;
  logic [COUNT_BITS-1:0]     bit_count_r;
  logic [COUNT_BITS-1:0]     bit_count_nxt;
  logic [FRAME_BITS-1:0]     shift_word_r;
  logic [FRAME_BITS-1:0]     shift_word_nxt;
  logic [TIMESTAMP_BITS-1:0] prev_time_r;
  logic [HALF_BITS-1:0]      held_address_r;
  logic [HALF_BITS-1:0]      held_command_r;
  logic [HALF_BITS-1:0]      held_address_nxt;
  logic [HALF_BITS-1:0]      held_command_nxt;

  // Result register
  logic                 out_valid_r;
  logic [HALF_BITS-1:0] out_address_r;
  logic [HALF_BITS-1:0] out_command_r;
  logic                 out_repeat_r;

  logic                      advance;
  logic [TIMESTAMP_BITS-1:0] delta;
  interval_class_t           cls;
  logic                      emit;
  logic                      emit_repeat;
  logic [FRAME_BITS-1:0]     bit_mask;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_pin_r   <= LISTEN_PIN_RST;
      tolerance_us_r <= TOLERANCE_US_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LISTEN_PIN:   listen_pin_r   <= cfg_data[PIN_BITS-1:0];
        REG_TOLERANCE_US: tolerance_us_r <= cfg_data[TOL_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Edge register advances whenever the result register can take a beat
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = edge_valid_r && !advance;

  // Capture edges; drop those on foreign pins here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_valid_r <= 1'b0;
    end else if (!in_stall) begin
      edge_valid_r <= in_valid && (in_pin_number == listen_pin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      edge_time_r <= in_edge_time_us[TIMESTAMP_BITS-1:0];
    end
  end

  // Wrapping interval to the previous decoded edge
  assign delta = edge_time_r - prev_time_r;

  necir_interval_cls #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_cls (
    .delta        (delta),
    .tolerance_us (tolerance_us_r),
    .cls          (cls)
  );

  assign bit_mask = FRAME_BITS'(1) << bit_count_r[INDEX_BITS-1:0];

  // Next decoder state for the edge in the edge register
  always_comb begin
    in_frame_nxt     = in_frame_r;
    bit_count_nxt    = bit_count_r;
    shift_word_nxt   = shift_word_r;
    held_address_nxt = held_address_r;
    held_command_nxt = held_command_r;
    emit             = 1'b0;
    emit_repeat      = 1'b0;
    if (!in_frame_r) begin
      if (cls.header) begin
        in_frame_nxt   = 1'b1;
        bit_count_nxt  = '0;
        shift_word_nxt = '0;
      end else if (cls.repeat_code) begin
        emit        = 1'b1;
        emit_repeat = 1'b1;
      end
    end else if (cls.bit_zero || cls.bit_one) begin
      if (!cls.bit_zero) begin
        shift_word_nxt = shift_word_r | bit_mask;
      end
      bit_count_nxt = bit_count_r + COUNT_BITS'(1);
      // Full frame: hold it for repeats and report it
      if (bit_count_nxt >= COUNT_BITS'(FRAME_BITS)) begin
        in_frame_nxt     = 1'b0;
        held_address_nxt = shift_word_nxt[HALF_BITS-1:0];
        held_command_nxt = shift_word_nxt[FRAME_BITS-1:HALF_BITS];
        emit             = 1'b1;
      end
    end else begin
      in_frame_nxt = 1'b0;
    end
  end

  // Commit decoder state when an edge leaves the edge register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      bit_count_r    <= '0;
      shift_word_r   <= '0;
      prev_time_r    <= '0;
      held_address_r <= '0;
      held_command_r <= '0;
    end else if (edge_valid_r && advance) begin
      in_frame_r     <= in_frame_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_word_r   <= shift_word_nxt;
      prev_time_r    <= edge_time_r;
      held_address_r <= held_address_nxt;
      held_command_r <= held_command_nxt;
    end
  end

  // Load a result beat, or drop the valid once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= edge_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && edge_valid_r && emit) begin
      out_address_r <= held_address_nxt;
      out_command_r <= held_command_nxt;
      out_repeat_r  <= emit_repeat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_address_r;
  assign out_frame_command = out_command_r;
  assign out_repeat_flag   = out_repeat_r;

endmodule : nec_ir_edge_interval_decoder_core

`default_nettype wire

[rtl/necir_checker.sv]
// ----------------------------------------------------------------------------
// necir_checker
// Port-level checks for the NEC infrared edge interval decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_checker
  import necir_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [HALF_BITS-1:0]      out_frame_address,
  input wire logic [HALF_BITS-1:0]      out_frame_command,
  input wire logic                      out_repeat_flag
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_address) &&
      $stable(out_frame_command) && $stable(out_repeat_flag))
    else $error("stalled result beat changed");

  // Reset empties both registers
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left a beat in flight");

  // Edge input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A fresh result follows an accepted edge beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted edge");

endmodule : necir_checker

bind nec_ir_edge_interval_decoder_core necir_checker u_necir_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_address (out_frame_address),
  .out_frame_command (out_frame_command),
  .out_repeat_flag   (out_repeat_flag)
);

`default_nettype wire
